[rtl/core/bvsm_pkg.sv]
`default_nettype none
package bvsm_pkg;

  // configuration register indexes
  localparam logic [3:0] CFG_GAIN      = 4'd0;
  localparam logic [3:0] CFG_OFFSET    = 4'd1;
  localparam logic [3:0] CFG_LOW_THR   = 4'd2;
  localparam logic [3:0] CFG_HIGH_THR  = 4'd3;
  localparam logic [3:0] CFG_PT_COUNT  = 4'd4;
  localparam logic [3:0] CFG_VOLTS_LO  = 4'd5;
  localparam logic [3:0] CFG_VOLTS_HI  = 4'd6;
  localparam logic [3:0] CFG_PERCENTS  = 4'd7;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // percent limits
  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] PCT_TOP   = 7'd99;
  localparam logic [6:0] PCT_FLOOR = 7'd1;

  // serial divider sizes: dividend below 100 * 65535, quotient below 100
  localparam int DIV_NUM_W = 23;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_Q_W   = 7;

  typedef enum logic [2:0] {
    BAT_NONE    = 3'd0,
    BAT_HIGH    = 3'd1,
    BAT_LOW     = 3'd2,
    BAT_EMPTY   = 3'd3,
    BAT_UNKNOWN = 3'd4
  } bat_alert_t;

  typedef enum logic [1:0] {
    PLUG_NONE    = 2'd0,
    PLUG_WRONG   = 2'd1,
    PLUG_UNKNOWN = 2'd2
  } plug_alert_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_CLAMP,
    ST_EDGE,
    ST_SEARCH,
    ST_SEG,
    ST_NUM,
    ST_TERM,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] gain_q16;
    logic [31:0] offset_q16;
    logic [15:0] low_threshold_mv;
    logic [15:0] high_threshold_mv;
    logic [3:0]  point_count;
    logic [63:0] point_volts_low;
    logic [63:0] point_volts_high;
    logic [63:0] point_percents;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] supply_mv;
    logic [6:0]  charge_percent;
    bat_alert_t  battery_alert;
    plug_alert_t plug_alert;
  } res_t;

  function automatic logic [15:0] volt_of(input logic [63:0] vlow, input logic [63:0] vhigh,
                                          input logic [2:0] k);
    logic [15:0] v;
    case (k)
      3'd0:    v = vlow[15:0];
      3'd1:    v = vlow[31:16];
      3'd2:    v = vlow[47:32];
      3'd3:    v = vlow[63:48];
      3'd4:    v = vhigh[15:0];
      3'd5:    v = vhigh[31:16];
      3'd6:    v = vhigh[47:32];
      default: v = vhigh[63:48];
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pct_of(input logic [63:0] pcts, input logic [2:0] k);
    return pcts[8*k +: 8];
  endfunction

endpackage
`default_nettype wire

[rtl/core/bvsm_cfg.sv]
`default_nettype none
module bvsm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bvsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bvsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bvsm_pkg::cfg_t                        cfg_o
);

  bvsm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q16          <= 32'h0001_0000;
      cfg_r.offset_q16        <= 32'h0;
      cfg_r.low_threshold_mv  <= 16'h0;
      cfg_r.high_threshold_mv <= 16'hFFFF;
      cfg_r.point_count       <= 4'd2;
      cfg_r.point_volts_low   <= 64'h0000_0000_FFFF_0000;
      cfg_r.point_volts_high  <= 64'h0;
      cfg_r.point_percents    <= 64'h6400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bvsm_pkg::CFG_GAIN:     cfg_r.gain_q16          <= cfg_data[31:0];
        bvsm_pkg::CFG_OFFSET:   cfg_r.offset_q16        <= cfg_data[31:0];
        bvsm_pkg::CFG_LOW_THR:  cfg_r.low_threshold_mv  <= cfg_data[15:0];
        bvsm_pkg::CFG_HIGH_THR: cfg_r.high_threshold_mv <= cfg_data[15:0];
        bvsm_pkg::CFG_PT_COUNT: cfg_r.point_count       <= cfg_data[3:0];
        bvsm_pkg::CFG_VOLTS_LO: cfg_r.point_volts_low   <= cfg_data;
        bvsm_pkg::CFG_VOLTS_HI: cfg_r.point_volts_high  <= cfg_data;
        bvsm_pkg::CFG_PERCENTS: cfg_r.point_percents    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

[rtl/core/bvsm_div.sv]
`default_nettype none
module bvsm_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  bvsm_pkg::div_req_t req_i,
  output bvsm_pkg::div_rsp_t rsp_o
);

  localparam int NW = bvsm_pkg::DIV_NUM_W;
  localparam int DW = bvsm_pkg::DIV_DEN_W;
  localparam int QW = bvsm_pkg::DIV_Q_W;
  localparam int CW = $clog2(QW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] dsh_r;
  logic [QW-1:0] q_r;
  logic          fits;

  assign fits = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r <= req_i.dividend;
      dsh_r <= NW'({req_i.divisor, {(QW-1){1'b0}}});
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QW-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = q_r;

endmodule
`default_nettype wire

[rtl/core/bvsm_ctrl.sv]
`default_nettype none
module bvsm_ctrl #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  bvsm_pkg::cfg_t          cfg_i,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] in_adc,
  output logic                    in_ready,
  input  wire logic               res_ready,
  output logic                    res_valid,
  output bvsm_pkg::res_t          res_o,
  output bvsm_pkg::div_req_t      div_req_o,
  input  bvsm_pkg::div_rsp_t      div_rsp_i
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [3:0] MaxPts = 4'(MAX_POINTS);

  bvsm_pkg::state_t state_r, state_nxt;

  logic               neg_r;
  logic [14:0]        adc_r;
  logic [46:0]        prod_r;
  logic signed [48:0] v_r;
  logic [15:0]        u_r;
  logic               over_r;
  logic               under_r;
  logic [IDX_W-1:0]   k_r;
  logic [IDX_W-1:0]   i1_r;
  logic [15:0]        den_r;
  logic signed [8:0]  dp_r;
  logic signed [16:0] du_r;
  logic [7:0]         p1_r;
  logic               flat_r;
  logic signed [25:0] num_r;
  logic signed [26:0] t_r;
  logic [6:0]         pct_r;

  logic [IDX_W-1:0]   nm1;
  logic               at_first;
  logic               at_last;
  logic               below_k;
  logic [2:0]         seg_lo;
  logic [2:0]         seg_hi;
  logic [15:0]        v1;
  logic [15:0]        v2;
  logic [7:0]         p1;
  logic [7:0]         p2;
  logic signed [16:0] den17;
  logic signed [16:0] du17;
  logic signed [8:0]  dp9;
  logic [22:0]        hund;
  logic               t_full;
  logic               t_nonpos;

  // point count clamped to 2..MAX_POINTS, kept as last index
  always_comb begin
    if (cfg_i.point_count < 4'd2) begin
      nm1 = IDX_W'(1);
    end else if (cfg_i.point_count > MaxPts) begin
      nm1 = IDX_W'(MAX_POINTS - 1);
    end else begin
      nm1 = IDX_W'(cfg_i.point_count - 4'd1);
    end
  end

  assign at_first = u_r <= bvsm_pkg::volt_of(cfg_i.point_volts_low, cfg_i.point_volts_high,
                                             3'd0);
  assign at_last  = u_r >= bvsm_pkg::volt_of(cfg_i.point_volts_low, cfg_i.point_volts_high,
                                             3'(nm1));
  assign below_k  = u_r < bvsm_pkg::volt_of(cfg_i.point_volts_low, cfg_i.point_volts_high,
                                            3'(k_r));

  assign seg_lo = 3'(i1_r);
  assign seg_hi = 3'(i1_r) + 3'd1;
  assign v1 = bvsm_pkg::volt_of(cfg_i.point_volts_low, cfg_i.point_volts_high, seg_lo);
  assign v2 = bvsm_pkg::volt_of(cfg_i.point_volts_low, cfg_i.point_volts_high, seg_hi);
  assign p1 = bvsm_pkg::pct_of(cfg_i.point_percents, seg_lo);
  assign p2 = bvsm_pkg::pct_of(cfg_i.point_percents, seg_hi);

  assign den17 = $signed({1'b0, v2}) - $signed({1'b0, v1});
  assign du17  = $signed({1'b0, u_r}) - $signed({1'b0, v1});
  assign dp9   = $signed({1'b0, p2}) - $signed({1'b0, p1});

  assign hund     = 23'(den_r) * 23'(bvsm_pkg::PCT_FULL);
  assign t_full   = !t_r[26] && (t_r[25:0] >= {3'b000, hund});
  assign t_nonpos = t_r[26] || (t_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bvsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_adc[15] ? bvsm_pkg::ST_FINISH : bvsm_pkg::ST_MUL;
        end
      end
      bvsm_pkg::ST_MUL:   state_nxt = bvsm_pkg::ST_SCALE;
      bvsm_pkg::ST_SCALE: state_nxt = bvsm_pkg::ST_CLAMP;
      bvsm_pkg::ST_CLAMP: state_nxt = bvsm_pkg::ST_EDGE;
      bvsm_pkg::ST_EDGE: begin
        state_nxt = (at_first || at_last) ? bvsm_pkg::ST_SEG : bvsm_pkg::ST_SEARCH;
      end
      bvsm_pkg::ST_SEARCH: begin
        if (below_k || k_r == nm1) begin
          state_nxt = bvsm_pkg::ST_SEG;
        end
      end
      bvsm_pkg::ST_SEG:  state_nxt = bvsm_pkg::ST_NUM;
      bvsm_pkg::ST_NUM:  state_nxt = bvsm_pkg::ST_TERM;
      bvsm_pkg::ST_TERM: state_nxt = bvsm_pkg::ST_CHECK;
      bvsm_pkg::ST_CHECK: begin
        state_nxt = (t_full || t_nonpos) ? bvsm_pkg::ST_FINISH : bvsm_pkg::ST_DIV;
      end
      bvsm_pkg::ST_DIV: begin
        if (div_rsp_i.done) begin
          state_nxt = bvsm_pkg::ST_FINISH;
        end
      end
      bvsm_pkg::ST_FINISH: begin
        if (res_ready) begin
          state_nxt = bvsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bvsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bvsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    in_ready           = 1'b0;
    res_valid          = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = t_r[22:0];
    div_req_o.divisor  = den_r;
    unique case (state_r)
      bvsm_pkg::ST_IDLE:   in_ready = 1'b1;
      bvsm_pkg::ST_CHECK:  div_req_o.start = !(t_full || t_nonpos);
      bvsm_pkg::ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      bvsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg_r <= in_adc[15];
          adc_r <= in_adc[14:0];
        end
      end
      bvsm_pkg::ST_MUL: begin
        prod_r <= 47'(adc_r) * 47'(cfg_i.gain_q16);
      end
      bvsm_pkg::ST_SCALE: begin
        v_r <= $signed({2'b00, prod_r}) + $signed({{17{cfg_i.offset_q16[31]}}, cfg_i.offset_q16});
      end
      bvsm_pkg::ST_CLAMP: begin
        if (v_r[48]) begin
          u_r <= 16'd0;
        end else if (|v_r[47:32]) begin
          u_r <= 16'hFFFF;
        end else begin
          u_r <= v_r[31:16];
        end
        over_r  <= v_r > $signed({17'b0, cfg_i.high_threshold_mv, 16'b0});
        under_r <= v_r < $signed({17'b0, cfg_i.low_threshold_mv, 16'b0});
      end
      bvsm_pkg::ST_EDGE: begin
        k_r <= IDX_W'(1);
        if (at_first) begin
          i1_r <= '0;
        end else if (at_last) begin
          i1_r <= nm1 - IDX_W'(1);
        end
      end
      bvsm_pkg::ST_SEARCH: begin
        i1_r <= k_r - IDX_W'(1);
        k_r  <= k_r + IDX_W'(1);
      end
      bvsm_pkg::ST_SEG: begin
        p1_r   <= p1;
        du_r   <= du17;
        flat_r <= den17 == '0;
        if (den17 == '0) begin
          den_r <= 16'd1;
          dp_r  <= dp9;
        end else if (den17[16]) begin
          // falling segment: flip both signs so the divisor stays positive
          den_r <= 16'(-den17);
          dp_r  <= -dp9;
        end else begin
          den_r <= den17[15:0];
          dp_r  <= dp9;
        end
      end
      bvsm_pkg::ST_NUM: begin
        num_r <= flat_r ? 26'sd0 : dp_r * du_r;
      end
      bvsm_pkg::ST_TERM: begin
        t_r <= $signed({1'b0, p1_r}) * $signed({1'b0, den_r}) + num_r;
      end
      bvsm_pkg::ST_CHECK: begin
        if (t_full) begin
          pct_r <= bvsm_pkg::PCT_TOP;
        end else if (t_nonpos) begin
          pct_r <= bvsm_pkg::PCT_FLOOR;
        end
      end
      bvsm_pkg::ST_DIV: begin
        if (div_rsp_i.done) begin
          pct_r <= div_rsp_i.quotient;
        end
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    if (neg_r) begin
      res_o.valid_res      = 1'b0;
      res_o.supply_mv      = 16'd0;
      res_o.charge_percent = 7'd0;
      res_o.battery_alert  = bvsm_pkg::BAT_UNKNOWN;
      res_o.plug_alert     = bvsm_pkg::PLUG_UNKNOWN;
    end else begin
      res_o.valid_res      = 1'b1;
      res_o.supply_mv      = u_r;
      res_o.charge_percent = pct_r;
      if (over_r) begin
        res_o.battery_alert = bvsm_pkg::BAT_HIGH;
      end else if (under_r) begin
        res_o.battery_alert = (pct_r == 7'd0) ? bvsm_pkg::BAT_EMPTY : bvsm_pkg::BAT_LOW;
      end else begin
        res_o.battery_alert = bvsm_pkg::BAT_NONE;
      end
      res_o.plug_alert = (over_r || under_r) ? bvsm_pkg::PLUG_WRONG : bvsm_pkg::PLUG_NONE;
    end
  end

endmodule
`default_nettype wire

[rtl/core/battery_voltage_soc_monitor.sv]
`default_nettype none
// Battery supply voltage and state-of-charge monitor. Each item is one signed ADC
// millivolt reading; a negative reading reports unknown alerts with valid_res low.
// A usable reading is scaled by gain and offset in Q16.16, saturated to 0..65535 mV,
// and its charge percent is interpolated on a voltage/percent table of up to
// MAX_POINTS points (99 at or above 100, 1 at or below zero, truncated in between,
// so 0 is possible). The block works on one item at a time: a usable reading is
// scaled, placed on its table segment (a search steps one table point per cycle)
// and divided by the serial divider, which is skipped when the percent clamps,
// before it reaches the output register; a negative reading skips all of these. A
// result waits in the output register while the next item is accepted. Configuration
// writes are taken at any time but must only be made while the block is idle.
module battery_voltage_soc_monitor #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              in_adc_millivolts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_valid_res,
  output logic [15:0]                          out_supply_mv,
  output logic [6:0]                           out_charge_percent,
  output logic [2:0]                           out_battery_alert,
  output logic [1:0]                           out_plug_alert,
  input  wire logic                            cfg_we,
  input  wire logic [bvsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bvsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  bvsm_pkg::cfg_t     cfg;
  bvsm_pkg::div_req_t div_req;
  bvsm_pkg::div_rsp_t div_rsp;
  bvsm_pkg::res_t     res;
  bvsm_pkg::res_t     out_res_r;
  logic               out_valid_r;
  logic               in_ready;
  logic               res_valid;
  logic               res_ready;

  bvsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  bvsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  bvsm_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_valid  (in_valid),
    .in_adc    (in_adc_millivolts),
    .in_ready  (in_ready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_o     (res),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid_r || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_valid_res      = out_res_r.valid_res;
  assign out_supply_mv      = out_res_r.supply_mv;
  assign out_charge_percent = out_res_r.charge_percent;
  assign out_battery_alert  = out_res_r.battery_alert;
  assign out_plug_alert     = out_res_r.plug_alert;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an item");

  a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_supply_mv == 16'd0 && out_charge_percent == 7'd0 &&
       out_battery_alert == bvsm_pkg::BAT_UNKNOWN && out_plug_alert == bvsm_pkg::PLUG_UNKNOWN))
    else $error("failed reading with non-default result fields");

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> (out_charge_percent <= bvsm_pkg::PCT_TOP))
    else $error("charge percent above clamp");

  a_alert_pairing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res && out_battery_alert != bvsm_pkg::BAT_NONE) |->
      (out_plug_alert == bvsm_pkg::PLUG_WRONG))
    else $error("battery alert without plug alert");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_POINTS = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_SETS = 8;
  localparam int READINGS_PER_SET = 69;
  localparam logic [3:0] CFG_UNUSED = 4'd15;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_adc_millivolts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_valid_res;
  logic [15:0] out_supply_mv;
  logic [6:0] out_charge_percent;
  logic [2:0] out_battery_alert;
  logic [1:0] out_plug_alert;
  logic cfg_we = 1'b0;
  logic [bvsm_pkg::CFG_IDX_W-1:0] cfg_index = bvsm_pkg::CFG_GAIN;
  logic [bvsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bvsm_pkg::cfg_t active_cfg;
  logic signed [15:0] pending_readings[$];
  bvsm_pkg::res_t expected_results[$];
  int readings_queued = 0;
  int readings_accepted = 0;
  int failed_reads = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  battery_voltage_soc_monitor u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_adc_millivolts(in_adc_millivolts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_valid_res(out_valid_res),
    .out_supply_mv(out_supply_mv),
    .out_charge_percent(out_charge_percent),
    .out_battery_alert(out_battery_alert),
    .out_plug_alert(out_plug_alert),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint table_volt(int k);
    if (k < 4) begin
      return longint'(active_cfg.point_volts_low[16*k +: 16]);
    end
    return longint'(active_cfg.point_volts_high[16*(k-4) +: 16]);
  endfunction

  function automatic longint table_pct(int k);
    return longint'(active_cfg.point_percents[8*k +: 8]);
  endfunction

  // interpolated charge on the segment holding mv, clamped to 1..99 (0 for 0 < r < 1)
  function automatic int charge_percent_for(longint mv);
    int n;
    int lo_i;
    int hi_i;
    longint v1;
    longint v2;
    longint p1;
    longint p2;
    longint num;
    longint den;
    longint scaled;
    n = int'(active_cfg.point_count);
    if (n < 2) n = 2;
    if (n > TABLE_POINTS) n = TABLE_POINTS;
    lo_i = 0;
    hi_i = 1;
    if (mv <= table_volt(0)) begin
      lo_i = 0;
      hi_i = 1;
    end else if (mv >= table_volt(n - 1)) begin
      lo_i = n - 2;
      hi_i = n - 1;
    end else begin
      for (int k = 1; k < n; k++) begin
        if (mv < table_volt(k)) begin
          hi_i = k;
          lo_i = k - 1;
          break;
        end
      end
    end
    v1 = table_volt(lo_i);
    v2 = table_volt(hi_i);
    p1 = table_pct(lo_i);
    p2 = table_pct(hi_i);
    den = v2 - v1;
    if (den == 0) begin
      num = 0;
      den = 1;
    end else begin
      num = (p2 - p1) * (mv - v1);
      if (den < 0) begin
        den = -den;
        num = -num;
      end
    end
    scaled = p1 * den + num;
    if (scaled >= 100 * den) return 99;
    if (scaled <= 0) return 1;
    return int'(scaled / den);
  endfunction

  function automatic bvsm_pkg::res_t predict_result(logic signed [15:0] adc);
    bvsm_pkg::res_t r;
    longint volts_q16;
    longint mv;
    longint lo_q16;
    longint hi_q16;
    int pct;
    if (adc < 0) begin
      r.valid_res = 1'b0;
      r.supply_mv = '0;
      r.charge_percent = '0;
      r.battery_alert = bvsm_pkg::BAT_UNKNOWN;
      r.plug_alert = bvsm_pkg::PLUG_UNKNOWN;
      return r;
    end
    volts_q16 = longint'(adc) * longint'(active_cfg.gain_q16)
                + longint'($signed(active_cfg.offset_q16));
    if (volts_q16 < 0) begin
      mv = 0;
    end else begin
      mv = volts_q16 / 65536;
      if (mv > 65535) mv = 65535;
    end
    pct = charge_percent_for(mv);
    lo_q16 = longint'(active_cfg.low_threshold_mv) * 65536;
    hi_q16 = longint'(active_cfg.high_threshold_mv) * 65536;
    r.valid_res = 1'b1;
    r.supply_mv = mv[15:0];
    r.charge_percent = pct[6:0];
    if (volts_q16 > hi_q16) begin
      r.battery_alert = bvsm_pkg::BAT_HIGH;
    end else if (volts_q16 < lo_q16) begin
      r.battery_alert = (pct == 0) ? bvsm_pkg::BAT_EMPTY : bvsm_pkg::BAT_LOW;
    end else begin
      r.battery_alert = bvsm_pkg::BAT_NONE;
    end
    r.plug_alert = (volts_q16 > hi_q16 || volts_q16 < lo_q16) ? bvsm_pkg::PLUG_WRONG
                                                               : bvsm_pkg::PLUG_NONE;
    return r;
  endfunction

  // reading driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_adc_millivolts));
        readings_accepted++;
        if (in_adc_millivolts < 0) failed_reads++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_adc_millivolts <= pending_readings.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    bvsm_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no reading outstanding: supply_mv %0d", out_supply_mv);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_valid_res !== want.valid_res) begin
            $error("valid_res mismatch: expected %0d, got %0d", want.valid_res, out_valid_res);
            error_count++;
          end
          if (out_supply_mv !== want.supply_mv) begin
            $error("supply_mv mismatch: expected %0d, got %0d", want.supply_mv, out_supply_mv);
            error_count++;
          end
          if (out_charge_percent !== want.charge_percent) begin
            $error("charge_percent mismatch: expected %0d, got %0d",
                   want.charge_percent, out_charge_percent);
            error_count++;
          end
          if (out_battery_alert !== want.battery_alert) begin
            $error("battery_alert mismatch: expected %0d, got %0d",
                   want.battery_alert, out_battery_alert);
            error_count++;
          end
          if (out_plug_alert !== want.plug_alert) begin
            $error("plug_alert mismatch: expected %0d, got %0d",
                   want.plug_alert, out_plug_alert);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      bvsm_pkg::CFG_GAIN:     active_cfg.gain_q16 = data[31:0];
      bvsm_pkg::CFG_OFFSET:   active_cfg.offset_q16 = data[31:0];
      bvsm_pkg::CFG_LOW_THR:  active_cfg.low_threshold_mv = data[15:0];
      bvsm_pkg::CFG_HIGH_THR: active_cfg.high_threshold_mv = data[15:0];
      bvsm_pkg::CFG_PT_COUNT: active_cfg.point_count = data[3:0];
      bvsm_pkg::CFG_VOLTS_LO: active_cfg.point_volts_low = data;
      bvsm_pkg::CFG_VOLTS_HI: active_cfg.point_volts_high = data;
      bvsm_pkg::CFG_PERCENTS: active_cfg.point_percents = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [31:0] gain, logic [31:0] offset, logic [15:0] lo_thr,
                               logic [15:0] hi_thr, logic [3:0] count, logic [63:0] vlo,
                               logic [63:0] vhi, logic [63:0] pcts);
    write_reg(bvsm_pkg::CFG_GAIN, {32'd0, gain});
    write_reg(bvsm_pkg::CFG_OFFSET, {32'd0, offset});
    write_reg(bvsm_pkg::CFG_LOW_THR, {48'd0, lo_thr});
    write_reg(bvsm_pkg::CFG_HIGH_THR, {48'd0, hi_thr});
    write_reg(bvsm_pkg::CFG_PT_COUNT, {60'd0, count});
    write_reg(bvsm_pkg::CFG_VOLTS_LO, vlo);
    write_reg(bvsm_pkg::CFG_VOLTS_HI, vhi);
    write_reg(bvsm_pkg::CFG_PERCENTS, pcts);
    settings_loaded++;
  endtask

  task automatic random_settings();
    logic [63:0] vlo;
    logic [63:0] vhi;
    logic [63:0] pcts;
    logic [31:0] gain;
    logic [31:0] offset;
    logic [15:0] lo_thr;
    logic [15:0] hi_thr;
    logic [3:0] count;
    int v;
    int p;
    bit scrambled;
    scrambled = ($urandom_range(3) == 0);
    v = $urandom_range(4000);
    p = $urandom_range(10);
    for (int k = 0; k < TABLE_POINTS; k++) begin
      logic [15:0] pv;
      logic [7:0] pp;
      if (scrambled) begin
        pv = 16'($urandom);
        pp = 8'($urandom);
      end else begin
        pv = (v > 65535) ? 16'hFFFF : v[15:0];
        pp = (p > 255) ? 8'hFF : p[7:0];
        v += $urandom_range(1, 9000);
        p += $urandom_range(0, 20);
      end
      if (k < 4) vlo[16*k +: 16] = pv;
      else vhi[16*(k-4) +: 16] = pv;
      pcts[8*k +: 8] = pp;
    end
    gain = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0000_8000, 32'h0002_0000);
    if ($urandom_range(7) == 0) offset = $urandom;
    else offset = int'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
    lo_thr = 16'($urandom_range(20000));
    hi_thr = 16'($urandom_range(30000, 65535));
    count = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2, 8));
    load_settings(gain, offset, lo_thr, hi_thr, count, vlo, vhi, pcts);
  endtask

  task automatic queue_reading(logic signed [15:0] adc);
    pending_readings.push_back(adc);
    readings_queued++;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 50; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 50; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // every reading in and every result out, then let the block settle
  task automatic drain();
    while (readings_accepted != readings_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    active_cfg.gain_q16 = 32'h0001_0000;
    active_cfg.offset_q16 = '0;
    active_cfg.low_threshold_mv = '0;
    active_cfg.high_threshold_mv = 16'hFFFF;
    active_cfg.point_count = 4'd2;
    active_cfg.point_volts_low = 64'h0000_0000_FFFF_0000;
    active_cfg.point_volts_high = '0;
    active_cfg.point_percents = 64'h6400;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // power-on table: field extremes and failed reads
    set_idling(0);
    queue_reading(-16'sd32768);
    queue_reading(-16'sd1);
    queue_reading(16'sd0);
    queue_reading(16'sd1);
    queue_reading(16'sd32767);
    queue_reading(16'sh5555);
    queue_reading(16'sh2AAA);
    drain();

    // maximum gain, most negative offset: negative supply and saturation
    load_settings(32'hFFFF_FFFF, 32'h8000_0000, 16'd100, 16'd60000, 4'd8,
                  {16'd30000, 16'd20000, 16'd10000, 16'd0},
                  {16'd65535, 16'd60000, 16'd50000, 16'd40000},
                  {8'd100, 8'd95, 8'd80, 8'd65, 8'd50, 8'd30, 8'd10, 8'd0});
    set_idling(1);
    queue_reading(16'sd0);
    queue_reading(16'sd1);
    queue_reading(16'sd2);
    queue_reading(16'sd32767);
    drain();

    // percent truncated to zero below low threshold gives empty; count below 2
    load_settings(32'h0001_0000, 32'h0, 16'd3000, 16'd4000, 4'd1,
                  {16'd0, 16'd0, 16'd2000, 16'd1000}, 64'd0, 64'h0100);
    set_idling(2);
    queue_reading(16'sd1500);
    queue_reading(16'sd500);
    queue_reading(16'sd3500);
    queue_reading(16'sd4000);
    queue_reading(16'sd5000);
    drain();

    // unsorted table with equal voltages, percents above 100, count above the maximum
    load_settings(32'h0001_8000, 32'h7FFF_FFFF, 16'd0, 16'd65535, 4'd15,
                  {16'd20000, 16'd3000, 16'd5000, 16'd5000},
                  {16'd10000, 16'd60000, 16'd40000, 16'd40000},
                  {8'd90, 8'd30, 8'd120, 8'd0, 8'd255, 8'd50, 8'd200, 8'd10});
    set_idling(3);
    queue_reading(16'sd0);
    queue_reading(16'sd1000);
    queue_reading(16'sd5000);
    queue_reading(16'sd20000);
    queue_reading(16'sd32767);
    drain();

    // zero gain, offset just below zero; a write to an unmapped index must do nothing
    load_settings(32'h0, 32'hFFFF_FFFF, 16'd0, 16'd0, 4'd2,
                  64'h0000_0000_FFFF_0000, 64'd0, 64'h6400);
    write_reg(CFG_UNUSED, '1);
    set_idling(0);
    queue_reading(16'sd0);
    queue_reading(16'sd32767);
    queue_reading(-16'sd32768);
    drain();

    for (int s = 0; s < RANDOM_SETS; s++) begin
      random_settings();
      set_idling(s);
      for (int i = 0; i < READINGS_PER_SET; i++) begin
        pick = $urandom_range(99);
        if (pick < 15) queue_reading(16'($urandom));
        else if (pick < 18) queue_reading(16'sd32767);
        else if (pick < 20) queue_reading(16'sd0);
        else queue_reading(16'($urandom_range(32767)));
      end
      drain();
    end

    $display("%0d readings accepted (%0d failed reads), %0d results checked",
             readings_accepted, failed_reads, results_checked);
    $display("table and scaling settings loaded: %0d, plus power-on defaults",
             settings_loaded);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[battery_voltage_soc_monitor.f]
rtl/core/bvsm_pkg.sv
rtl/core/bvsm_cfg.sv
rtl/core/bvsm_div.sv
rtl/core/bvsm_ctrl.sv
rtl/core/battery_voltage_soc_monitor.sv
tb/tb.sv
